// ===== hw/rtl/kmhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kmhpq_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CountW = $clog2(Capacity + 1);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [2:0] {
    StInserted = 3'd0,
    StRaised   = 3'd1,
    StIgnored  = 3'd2,
    StFull     = 3'd3,
    StExtract  = 3'd4,
    StEmpty    = 3'd5
  } status_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/kmhpq_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kmhpq_store (
  input  wire                 clk_i,
  input  kmhpq_pkg::mem_req_t req_i,
  output kmhpq_pkg::entry_t   rd_data_o
);
  import kmhpq_pkg::*;

  entry_t mem_q [Capacity];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule
`default_nettype wire

// ===== hw/rtl/kmhpq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kmhpq_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 operation_i,
  input  wire  [31:0]         item_key_i,
  input  wire  [31:0]         new_priority_i,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [2:0]          status_o,
  output logic [31:0]         out_key_o,
  output logic [31:0]         out_priority_o,
  output logic [6:0]          entry_count_o,
  output kmhpq_pkg::mem_req_t req_o,
  input  kmhpq_pkg::entry_t   rd_data_i
);
  import kmhpq_pkg::*;

  // Every memory read is issued in one state and consumed in the next.
  typedef enum logic [11:0] {
    SIdle   = 12'b000000000001,
    SSrchRd = 12'b000000000010,
    SSrchCk = 12'b000000000100,
    SUpRd   = 12'b000000001000,
    SUpCk   = 12'b000000010000,
    SExRoot = 12'b000000100000,
    SExLast = 12'b000001000000,
    SDnL    = 12'b000010000000,
    SDnR    = 12'b000100000000,
    SDnCk   = 12'b001000000000,
    SDone   = 12'b010000000000,
    SLand   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  count_t fill_q, fill_d;
  count_t idx_q, idx_d;
  count_t best_q, best_d;
  entry_t cur_q, cur_d;
  entry_t bent_q, bent_d;
  logic [31:0] key_q, key_d, prio_q, prio_d;
  logic [2:0] status_q, status_d;
  entry_t oent_q, oent_d;
  logic out_valid_q, out_valid_d;
  mem_req_t req;

  logic [CountW:0] lchild, rchild;
  assign lchild = {idx_q, 1'b1};
  assign rchild = {idx_q, 1'b0} + (CountW+1)'(2);

  always_comb begin
    state_d = state_q; fill_d = fill_q; idx_d = idx_q; best_d = best_q;
    cur_d = cur_q; bent_d = bent_q; key_d = key_q; prio_d = prio_q;
    status_d = status_q; oent_d = oent_q; out_valid_d = out_valid_q;
    req = '0;
    if (out_valid_q && !out_stall) out_valid_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_valid) begin
          key_d = item_key_i; prio_d = new_priority_i; oent_d = '0;
          idx_d = '0;
          if (operation_i) begin
            if (fill_q == '0) begin
              status_d = StEmpty; state_d = SDone;
            end else begin
              req.rd_en = 1'b1; req.rd_addr = '0; state_d = SExRoot;
            end
          end else if (fill_q == '0) begin
            status_d = StInserted; cur_d = '{key: item_key_i, prio: new_priority_i};
            fill_d = fill_q + count_t'(1); idx_d = '0;
            req.wr_en = 1'b1; req.wr_addr = '0; req.wr_data = cur_d; state_d = SDone;
          end else begin
            req.rd_en = 1'b1; req.rd_addr = '0; state_d = SSrchCk;
          end
        end
      end
      SSrchRd: begin
        req.rd_en = 1'b1; req.rd_addr = addr_t'(idx_q); state_d = SSrchCk;
      end
      SSrchCk: begin
        if (rd_data_i.key == key_q) begin
          if (prio_q > rd_data_i.prio) begin
            status_d = StRaised; cur_d = '{key: key_q, prio: prio_q};
            req.wr_en = 1'b1; req.wr_addr = addr_t'(idx_q); req.wr_data = cur_d;
            state_d = SUpRd;
          end else begin
            status_d = StIgnored; state_d = SDone;
          end
        end else if (idx_q + count_t'(1) < fill_q) begin
          idx_d = idx_q + count_t'(1); state_d = SSrchRd;
        end else if (fill_q == count_t'(Capacity)) begin
          status_d = StFull; state_d = SDone;
        end else begin
          status_d = StInserted; cur_d = '{key: key_q, prio: prio_q};
          idx_d = fill_q; fill_d = fill_q + count_t'(1);
          req.wr_en = 1'b1; req.wr_addr = addr_t'(fill_q); req.wr_data = cur_d;
          state_d = SUpRd;
        end
      end
      SUpRd: begin
        if (idx_q == '0) begin
          state_d = SDone;
        end else begin
          req.rd_en = 1'b1;
          req.rd_addr = addr_t'((idx_q - count_t'(1)) >> 1);
          state_d = SUpCk;
        end
      end
      SUpCk: begin
        // Parent is lower: swap, the entry climbs one level.
        if (rd_data_i.prio < cur_q.prio) begin
          req.wr_en = 1'b1; req.wr_addr = addr_t'(idx_q); req.wr_data = rd_data_i;
          idx_d = (idx_q - count_t'(1)) >> 1;
          bent_d = rd_data_i;
          state_d = SUpRd;
        end else begin
          state_d = SDone;
        end
        if (rd_data_i.prio < cur_q.prio && idx_d == '0) begin
          state_d = SLand;
        end
      end
      SExRoot: begin
        oent_d = rd_data_i; status_d = StExtract;
        fill_d = fill_q - count_t'(1);
        req.rd_en = 1'b1; req.rd_addr = addr_t'(fill_q - count_t'(1));
        state_d = SExLast;
      end
      SExLast: begin
        cur_d = rd_data_i; idx_d = '0;
        req.wr_en = 1'b1; req.wr_addr = '0; req.wr_data = rd_data_i;
        if (fill_q <= count_t'(1)) begin
          state_d = SDone;
        end else begin
          req.rd_en = 1'b1; req.rd_addr = addr_t'(lchild); state_d = SDnL;
        end
      end
      SDnL: begin
        best_d = idx_q; bent_d = cur_q;
        if (rd_data_i.prio > cur_q.prio) begin
          best_d = count_t'(lchild); bent_d = rd_data_i;
        end
        if (rchild < (CountW+1)'(fill_q)) begin
          req.rd_en = 1'b1; req.rd_addr = addr_t'(rchild); state_d = SDnR;
        end else begin
          state_d = SDnCk;
        end
      end
      SDnR: begin
        if (rd_data_i.prio > bent_q.prio) begin
          best_d = count_t'(rchild); bent_d = rd_data_i;
        end
        state_d = SDnCk;
      end
      SDnCk: begin
        if (best_q == idx_q) begin
          state_d = SDone;
        end else begin
          req.wr_en = 1'b1; req.wr_addr = addr_t'(idx_q); req.wr_data = bent_q;
          idx_d = best_q; state_d = SLand;
          if ({best_q, 1'b1} < {1'b0, fill_q}) begin
            req.rd_en = 1'b1; req.rd_addr = addr_t'({best_q, 1'b1}); state_d = SDnL;
          end
        end
      end
      SLand: begin
        // The swap took the write port in the state before, so the travelling entry lands here.
        req.wr_en = 1'b1; req.wr_addr = addr_t'(idx_q); req.wr_data = cur_q;
        state_d = SDone;
      end
      SDone: begin
        if (!out_valid_q || !out_stall) begin
          out_valid_d = 1'b1; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    // The travelling entry lands in its final slot when a sift check finds no swap; after a final swap SLand writes it.
    if ((state_q == SUpCk || state_q == SDnCk) && state_d == SDone) begin
      req.wr_en = 1'b1; req.wr_addr = addr_t'(idx_d); req.wr_data = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; fill_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; best_q <= best_d; cur_q <= cur_d; bent_q <= bent_d;
    key_q <= key_d; prio_q <= prio_d; status_q <= status_d; oent_q <= oent_d;
  end

  logic [2:0] st_q;
  entry_t res_q;
  logic [6:0] cnt_q;
  always_ff @(posedge clk_i) begin
    if (state_q == SDone && (!out_valid_q || !out_stall)) begin
      st_q <= status_q; res_q <= oent_q; cnt_q <= 7'(fill_q);
    end
  end

  assign in_stall = (state_q != SIdle);
  assign out_valid = out_valid_q;
  assign status_o = st_q;
  assign out_key_o = res_q.key;
  assign out_priority_o = res_q.prio;
  assign entry_count_o = cnt_q;
  assign req_o = req;
endmodule
`default_nettype wire

// ===== hw/rtl/keyed_max_heap_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Keyed max-heap priority queue of up to 64 (key, priority) entries.
// Input channel: in_valid/in_stall with operation_i (0 update, 1 extract),
// item_key_i and new_priority_i. One transaction in gives one result
// transaction out on out_valid/out_stall: status_o, out_key_o,
// out_priority_o and entry_count_o (entries held afterwards).
// An update scans the entry memory linearly for the key, then sifts the
// entry up, reading each parent and swapping, and lands it in its slot.
// An extract reads the root and the last entry, moves the last entry to
// the root and sifts it down, reading the children at each level.
// The memory takes one read and one write in the same cycle.
// One item is worked on at a time; in_stall is high while it is busy.
// The result sits in an output register, so a stalled receiver only holds
// back the next item's completion, never loses a result.
// Reset empties the queue; memory contents need no clearing since only
// entries below the fill count are read.
module keyed_max_heap_priority_queue_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         operation_i,
  input  wire  [31:0] item_key_i,
  input  wire  [31:0] new_priority_i,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  status_o,
  output logic [31:0] out_key_o,
  output logic [31:0] out_priority_o,
  output logic [6:0]  entry_count_o
);
  import kmhpq_pkg::*;

  mem_req_t req;
  entry_t   rd_data;

  kmhpq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .operation_i, .item_key_i,
    .new_priority_i, .out_valid, .out_stall, .status_o, .out_key_o,
    .out_priority_o, .entry_count_o, .req_o(req), .rd_data_i(rd_data)
  );

  kmhpq_store u_store (.clk_i, .req_i(req), .rd_data_o(rd_data));
endmodule
`default_nettype wire
